>>> sv/atl_pkg.sv
// Shared types, character codes and helpers for the assembly token lexer.
`timescale 1ns / 1ps

package atl_pkg;

  localparam int POSITION_WIDTH = 16;
  localparam int MAX_RESULTS    = 3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FEED    = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_ESCAPE  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    TOK_NEWLINE   = 3'd0,
    TOK_IDENT     = 3'd1,
    TOK_LABEL     = 3'd2,
    TOK_NUMBER    = 3'd3,
    TOK_ADDRESS   = 3'd4,
    TOK_STRING    = 3'd5,
    TOK_DIRECTIVE = 3'd6,
    TOK_END       = 3'd7
  } tok_t;

  typedef struct packed {
    mode_t      mode;
    tok_t       ptype;
    logic       bef;
    logic       halt;
  } ctl_t;

  typedef struct packed {
    tok_t        token_type;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        lex_error;
  } res_t;

  function automatic res_t mk_res(tok_t t, logic [7:0] b, logic v, logic f, logic l,
                                  logic [15:0] ln, logic [15:0] col, logic e);
    res_t r;
    r.token_type    = t;
    r.value_byte    = b;
    r.byte_valid    = v;
    r.token_first   = f;
    r.token_last    = l;
    r.line_number   = ln;
    r.column_number = col;
    r.lex_error     = e;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FEED) || (c == CH_CR) ||
           (c == CH_SPACE);
  endfunction

endpackage

>>> sv/assembly_token_lexer_unit.sv
// Latency: the first result of an input beat appears on the cycle after it is accepted.
// Throughput: one input beat per cycle while out_ready is high and each yields at most one
// result; a beat with more results holds off the next until all but its last have drained.
// Reset: synchronous, active low; mode, column counters, error halt and the result count clear
// at once and the line counter loads 1, with no clearing pass.
// Top level of the assembly token lexer: lexer state registers, step logic and result bank.
`timescale 1ns / 1ps

module assembly_token_lexer_unit #(
  parameter int POSITION_WIDTH = atl_pkg::POSITION_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_type,
  output logic [7:0]  out_value_byte,
  output logic        out_byte_valid,
  output logic        out_token_first,
  output logic        out_token_last,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_lex_error,
  output logic        out_last_of_run
);

  atl_pkg::ctl_t             ctl_r;
  atl_pkg::ctl_t             ctl_nxt;
  logic [POSITION_WIDTH-1:0] line_r;
  logic [POSITION_WIDTH-1:0] line_nxt;
  logic [POSITION_WIDTH-1:0] col_r;
  logic [POSITION_WIDTH-1:0] col_nxt;
  logic [POSITION_WIDTH-1:0] tstart_r;
  logic [POSITION_WIDTH-1:0] tstart_nxt;
  atl_pkg::res_t             res [atl_pkg::MAX_RESULTS];
  logic [1:0]                res_cnt;
  logic                      accept;
  atl_pkg::res_t             head;

  assign accept = in_valid && in_ready;

  atl_step #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_step (
    .char_byte   (in_char_byte),
    .end_of_input(in_end_of_input),
    .ctl_i       (ctl_r),
    .line_i      (line_r),
    .col_i       (col_r),
    .tstart_i    (tstart_r),
    .ctl_o       (ctl_nxt),
    .line_o      (line_nxt),
    .col_o       (col_nxt),
    .tstart_o    (tstart_nxt),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  atl_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res_i    (res),
    .res_cnt_i(res_cnt),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_o   (head),
    .last_o   (out_last_of_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= '{mode: atl_pkg::MODE_IDLE, ptype: atl_pkg::TOK_NEWLINE,
                    bef: 1'b0, halt: 1'b0};
      line_r   <= POSITION_WIDTH'(1);
      col_r    <= '0;
      tstart_r <= '0;
    end else if (accept) begin
      ctl_r    <= ctl_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tstart_r <= tstart_nxt;
    end
  end

  assign out_token_type    = head.token_type;
  assign out_value_byte    = head.value_byte;
  assign out_byte_valid    = head.byte_valid;
  assign out_token_first   = head.token_first;
  assign out_token_last    = head.token_last;
  assign out_line_number   = head.line_number;
  assign out_column_number = head.column_number;
  assign out_lex_error     = head.lex_error;

endmodule

>>> sv/atl_step.sv
// Single-pass lexer step: next state and up to three results for one input beat.
`timescale 1ns / 1ps

module atl_step #(
  parameter int POSITION_WIDTH = atl_pkg::POSITION_WIDTH
) (
  input  logic [7:0]                char_byte,
  input  logic                      end_of_input,
  input  atl_pkg::ctl_t             ctl_i,
  input  logic [POSITION_WIDTH-1:0] line_i,
  input  logic [POSITION_WIDTH-1:0] col_i,
  input  logic [POSITION_WIDTH-1:0] tstart_i,
  output atl_pkg::ctl_t             ctl_o,
  output logic [POSITION_WIDTH-1:0] line_o,
  output logic [POSITION_WIDTH-1:0] col_o,
  output logic [POSITION_WIDTH-1:0] tstart_o,
  output atl_pkg::res_t             res_o [atl_pkg::MAX_RESULTS],
  output logic [1:0]                res_cnt_o
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  logic [POSITION_WIDTH-1:0] col_inc;
  logic [POSITION_WIDTH-1:0] line_inc;
  logic [7:0]                esc_c;
  logic                      open_tok;
  logic                      do_idle;
  logic [1:0]                n;

  assign col_inc  = (col_i == POS_MAX) ? col_i : col_i + POS_ONE;
  assign line_inc = (line_i == POS_MAX) ? line_i : line_i + POS_ONE;
  assign open_tok = (ctl_i.mode == atl_pkg::MODE_IDENT) ||
                    (ctl_i.mode == atl_pkg::MODE_NUMBER) ||
                    (ctl_i.mode == atl_pkg::MODE_STRING) ||
                    (ctl_i.mode == atl_pkg::MODE_ESCAPE);

  always_comb begin
    case (char_byte)
      atl_pkg::CH_N: esc_c = atl_pkg::CH_NEWLINE;
      atl_pkg::CH_R: esc_c = atl_pkg::CH_CR;
      atl_pkg::CH_T: esc_c = atl_pkg::CH_TAB;
      default:       esc_c = char_byte;
    endcase
  end

  always_comb begin
    ctl_o    = ctl_i;
    line_o   = line_i;
    col_o    = col_i;
    tstart_o = tstart_i;
    n        = 2'd0;
    do_idle  = 1'b0;
    for (int k = 0; k < atl_pkg::MAX_RESULTS; k++) begin
      res_o[k] = '0;
    end

    if (ctl_i.halt) begin
      n = 2'd0;
    end else if (end_of_input || (char_byte == atl_pkg::CH_NEWLINE)) begin
      if (open_tok) begin
        res_o[n] = atl_pkg::mk_res(ctl_i.ptype, 8'd0, 1'b0, !ctl_i.bef, 1'b1,
                                   16'(line_i), 16'(tstart_i), 1'b0);
        n = n + 2'd1;
        ctl_o.bef = 1'b0;
      end
      ctl_o.mode = atl_pkg::MODE_IDLE;
      res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_NEWLINE, atl_pkg::CH_NEWLINE, 1'b1, 1'b1,
                                 1'b1, 16'(line_i), 16'(col_inc), 1'b0);
      n = n + 2'd1;
      if (end_of_input) begin
        res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                   16'(line_i), 16'(col_i), 1'b0);
        n = n + 2'd1;
        ctl_o.ptype = atl_pkg::TOK_NEWLINE;
        ctl_o.bef   = 1'b0;
        line_o      = POS_ONE;
        col_o       = '0;
        tstart_o    = '0;
      end else begin
        line_o = line_inc;
        col_o  = '0;
      end
    end else begin
      col_o = col_inc;
      case (ctl_i.mode)
        atl_pkg::MODE_COMMENT: begin
          do_idle = 1'b0;
        end
        atl_pkg::MODE_IDENT: begin
          if (atl_pkg::is_alpha(char_byte) || atl_pkg::is_digit(char_byte) ||
              (char_byte == atl_pkg::CH_UNDER) || (char_byte == atl_pkg::CH_PLUS)) begin
            res_o[n] = atl_pkg::mk_res(ctl_i.ptype, char_byte, 1'b1, !ctl_i.bef, 1'b0,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef = 1'b1;
          end else begin
            res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_IDENT, 8'd0, 1'b0, !ctl_i.bef, 1'b1,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef  = 1'b0;
            ctl_o.mode = atl_pkg::MODE_IDLE;
            do_idle    = 1'b1;
          end
        end
        atl_pkg::MODE_NUMBER: begin
          if (atl_pkg::is_digit(char_byte) || (char_byte == atl_pkg::CH_DOT)) begin
            res_o[n] = atl_pkg::mk_res(ctl_i.ptype, char_byte, 1'b1, !ctl_i.bef, 1'b0,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef = 1'b1;
          end else begin
            res_o[n] = atl_pkg::mk_res((char_byte == atl_pkg::CH_U) ? atl_pkg::TOK_ADDRESS
                                                                    : atl_pkg::TOK_NUMBER,
                                       8'd0, 1'b0, !ctl_i.bef, 1'b1,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef  = 1'b0;
            ctl_o.mode = atl_pkg::MODE_IDLE;
            do_idle    = (char_byte != atl_pkg::CH_U);
          end
        end
        atl_pkg::MODE_STRING: begin
          if (char_byte == atl_pkg::CH_QUOTE) begin
            res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_STRING, 8'd0, 1'b0, !ctl_i.bef, 1'b1,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef  = 1'b0;
            ctl_o.mode = atl_pkg::MODE_IDLE;
          end else if (char_byte == atl_pkg::CH_BSLASH) begin
            ctl_o.mode = atl_pkg::MODE_ESCAPE;
          end else begin
            res_o[n] = atl_pkg::mk_res(ctl_i.ptype, char_byte, 1'b1, !ctl_i.bef, 1'b0,
                                       16'(line_i), 16'(tstart_i), 1'b0);
            n = n + 2'd1;
            ctl_o.bef = 1'b1;
          end
        end
        atl_pkg::MODE_ESCAPE: begin
          res_o[n] = atl_pkg::mk_res(ctl_i.ptype, esc_c, 1'b1, !ctl_i.bef, 1'b0,
                                     16'(line_i), 16'(tstart_i), 1'b0);
          n = n + 2'd1;
          ctl_o.bef  = 1'b1;
          ctl_o.mode = atl_pkg::MODE_STRING;
        end
        default: begin
          ctl_o.mode = atl_pkg::MODE_IDLE;
          do_idle    = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (atl_pkg::is_space(char_byte)) begin
          do_idle = 1'b1;
        end else if (char_byte == atl_pkg::CH_SEMI) begin
          ctl_o.mode = atl_pkg::MODE_COMMENT;
        end else if (char_byte == atl_pkg::CH_COLON) begin
          res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_LABEL, char_byte, 1'b1, 1'b1, 1'b1,
                                     16'(line_i), 16'(col_inc), 1'b0);
          n = n + 2'd1;
        end else if (char_byte == atl_pkg::CH_HASH) begin
          res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_DIRECTIVE, char_byte, 1'b1, 1'b1, 1'b1,
                                     16'(line_i), 16'(col_inc), 1'b0);
          n = n + 2'd1;
        end else if (char_byte == atl_pkg::CH_QUOTE) begin
          ctl_o.mode  = atl_pkg::MODE_STRING;
          ctl_o.ptype = atl_pkg::TOK_STRING;
          ctl_o.bef   = 1'b0;
          tstart_o    = col_inc;
        end else if ((char_byte == atl_pkg::CH_MINUS) || atl_pkg::is_digit(char_byte) ||
                     atl_pkg::is_alpha(char_byte)) begin
          ctl_o.mode  = atl_pkg::is_alpha(char_byte) ? atl_pkg::MODE_IDENT
                                                     : atl_pkg::MODE_NUMBER;
          ctl_o.ptype = atl_pkg::is_alpha(char_byte) ? atl_pkg::TOK_IDENT
                                                     : atl_pkg::TOK_NUMBER;
          ctl_o.bef   = 1'b1;
          tstart_o    = col_inc;
          res_o[n] = atl_pkg::mk_res(ctl_o.ptype, char_byte, 1'b1, 1'b1, 1'b0,
                                     16'(line_i), 16'(col_inc), 1'b0);
          n = n + 2'd1;
        end else begin
          res_o[n] = atl_pkg::mk_res(atl_pkg::TOK_NEWLINE, char_byte, 1'b0, 1'b0, 1'b0,
                                     16'(line_i), 16'(col_inc), 1'b1);
          n = n + 2'd1;
          ctl_o.halt = 1'b1;
          ctl_o.mode = atl_pkg::MODE_IDLE;
        end
      end
    end
    res_cnt_o = n;
  end

endmodule

>>> sv/atl_outbuf.sv
// Result register bank: loads one step's results and drains them one beat at a time.
`timescale 1ns / 1ps

module atl_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  atl_pkg::res_t res_i [atl_pkg::MAX_RESULTS],
  input  logic [1:0]    res_cnt_i,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output atl_pkg::res_t head_o,
  output logic          last_o
);

  atl_pkg::res_t slot_r [atl_pkg::MAX_RESULTS];
  atl_pkg::res_t slot_nxt [atl_pkg::MAX_RESULTS];
  logic [1:0]    rem_r;
  logic [1:0]    rem_nxt;
  logic          pop;

  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_ready);
  assign head_o    = slot_r[0];
  assign last_o    = (rem_r == 2'd1);

  always_comb begin
    slot_nxt = slot_r;
    rem_nxt  = rem_r;
    if (load) begin
      slot_nxt = res_i;
      rem_nxt  = res_cnt_i;
    end else if (pop) begin
      for (int k = 0; k < atl_pkg::MAX_RESULTS - 1; k++) begin
        slot_nxt[k] = slot_r[k+1];
      end
      rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> sv/atl_checker.sv
// Port-level checker for the assembly token lexer, bound to the top level.
`timescale 1ns / 1ps

module atl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_token_type,
  input logic [7:0]  out_value_byte,
  input logic        out_byte_valid,
  input logic        out_token_first,
  input logic        out_token_last,
  input logic        out_lex_error,
  input logic        out_last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_type) &&
                                $stable(out_value_byte) && $stable(out_last_of_run))
    else $error("result beat changed while stalled");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_lex_error |=> !out_valid)
    else $error("result after lexer error");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_type == atl_pkg::TOK_END) |->
      out_last_of_run && out_token_first && out_token_last && !out_byte_valid)
    else $error("end token not a closing beat");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lex_error |-> out_last_of_run && !out_byte_valid && !out_token_last)
    else $error("error beat malformed");

endmodule

bind assembly_token_lexer_unit atl_checker u_atl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_token_type (out_token_type),
  .out_value_byte (out_value_byte),
  .out_byte_valid (out_byte_valid),
  .out_token_first(out_token_first),
  .out_token_last (out_token_last),
  .out_lex_error  (out_lex_error),
  .out_last_of_run(out_last_of_run)
);
